### rtl/core/sli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Types and constants shared by the sorted list store and its cells.
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int unsigned SLI_CAPACITY = 16;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_DELETE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_DELETED  = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_CMP,
		SQ_APPLY
	} seq_state_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] count;
	} result_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic               cmp;
		logic               ins;
		logic               del;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

### rtl/core/sli_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted store: holds a value, compares it with the request
// value and shifts towards either neighbour on insert or delete.
// ----------------------------------------------------------------------------
module sli_cell #(
	parameter int unsigned IDX    = 0,
	parameter int unsigned FILL_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sli_pkg::cell_cmd_t    cmd,
	input  logic [FILL_W-1:0]     fill,
	input  logic signed [31:0]    left_value,
	input  logic                  left_lt,
	input  logic signed [31:0]    right_value,
	output logic signed [31:0]    value,
	output logic                  lt,
	output logic                  hit
);
	import sli_pkg::*;

	logic signed [31:0] value_q;
	logic               lt_q;
	logic               hit_q;
	logic               occupied;

	assign occupied = (32'(fill) > IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.cmp) begin
			lt_q  <= occupied && (value_q < cmd.value);
			hit_q <= occupied && (value_q == cmd.value);
		end
	end

	// cells in front of the insert/delete point keep their value
	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_q) begin
			value_q <= left_lt ? cmd.value : left_value;
		end else if (cmd.del && !lt_q) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign lt    = lt_q;
	assign hit   = hit_q;

endmodule

### rtl/core/sorted_list_insert_delete_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core
// Bounded ascending multiset of signed 32-bit values held in a chain of
// compare-and-shift cells. Insert places ahead of equal values; delete
// removes the first equal value. One result per request.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | payload
//  item     | in  | item_valid / item_stall   | action, value
//  result   | out | result_valid / result_stall | status, count
//
//  A request has a compare step, where every cell compares against the value,
//  then an apply step, where the cells shift and the result is registered.
//  A new request is taken in the same cycle the previous one is applied.
//  Reset empties the store at once; no clearing pass.
//  A stalled result holds the apply step until the output register frees.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_core #(
	parameter int unsigned CAPACITY = sli_pkg::SLI_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sli_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sli_pkg::result_t result
);
	import sli_pkg::*;

	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

	seq_state_t         state_q, state_d;
	logic               action_q;
	logic signed [31:0] v_q;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic               res_valid_q;
	result_t            res_q;

	logic               out_free;
	logic               accept;
	logic               apply;
	logic               full;
	logic               found;
	logic               do_ins;
	logic               do_del;
	logic [1:0]         status_d;
	logic [31:0]        fill_ext;
	cell_cmd_t          cmd;

	logic signed [31:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_hit;

	assign out_free = !res_valid_q || !result_stall;
	assign apply    = (state_q == SQ_APPLY) && out_free;
	assign accept   = item_valid && !item_stall;
	assign full     = (32'(fill_q) >= CAPACITY);
	assign found    = |cell_hit;
	assign do_ins   = apply && (action_q == ACT_INSERT) && !full;
	assign do_del   = apply && (action_q == ACT_DELETE) && found;

	assign cmd.cmp   = (state_q == SQ_CMP);
	assign cmd.ins   = do_ins;
	assign cmd.del   = do_del;
	assign cmd.value = v_q;

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		case (state_q)
			SQ_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					state_d = SQ_CMP;
				end
			end
			SQ_CMP: begin
				state_d = SQ_APPLY;
			end
			SQ_APPLY: begin
				if (out_free) begin
					item_stall = 1'b0;
					state_d    = item_valid ? SQ_CMP : SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (do_ins) begin
			fill_d = fill_q + 1'b1;
		end else if (do_del) begin
			fill_d = fill_q - 1'b1;
		end
	end

	always_comb begin
		if (action_q == ACT_INSERT) begin
			status_d = full ? ST_FULL : ST_INSERTED;
		end else begin
			status_d = found ? ST_DELETED : ST_NOTFOUND;
		end
	end

	assign fill_ext = 32'(fill_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (apply) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= item.action;
			v_q      <= item.value;
		end
		if (apply) begin
			res_q.status <= status_d;
			res_q.count  <= fill_ext[4:0];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_value;
		logic               left_lt;
		logic signed [31:0] right_value;

		if (i == 0) begin : g_head
			assign left_value = v_q;
			assign left_lt    = 1'b1;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_lt    = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_next
			assign right_value = cell_value[i+1];
		end

		sli_cell #(
			.IDX    (i),
			.FILL_W (FILL_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.fill        (fill_q),
			.left_value  (left_value),
			.left_lt     (left_lt),
			.right_value (right_value),
			.value       (cell_value[i]),
			.lt          (cell_lt[i]),
			.hit         (cell_hit[i])
		);
	end

	// ---- checks ----
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= CAPACITY)
		else $error("fill above capacity");

	a_result_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == SQ_APPLY))
		else $error("result raised without an apply step");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> fill_q == $past(fill_q) + 1'b1)
		else $error("insert did not grow the store");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		do_del |=> fill_q == $past(fill_q) - 1'b1)
		else $error("delete did not shrink the store");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_CMP) |-> item_stall)
		else $error("request taken during compare");

endmodule
